// ===== rtl/m4t_pkg.sv =====
package m4t_pkg;

	// element format: signed fixed point, FRAC_W fraction bits
	localparam int ELEM_W   = 32;
	localparam int FRAC_W   = 16;
	localparam int IDX_W    = 4;
	localparam int NUM_ELEM = 16;
	localparam int VEC_LEN  = 4;
	localparam int TERM_W   = 2;
	localparam int PHASE_W  = 3;
	localparam int PROD_W   = 2 * ELEM_W;
	// four full products summed without loss
	localparam int ACC_W    = PROD_W + 2;

	typedef logic signed [ELEM_W-1:0] elem_t;

	localparam elem_t ELEM_ONE = ELEM_W'(64'd1 << FRAC_W);
	localparam elem_t ELEM_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
	localparam elem_t ELEM_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

	localparam logic [IDX_W-1:0] IDX_MAT_LAST = IDX_W'(NUM_ELEM - 1);
	localparam logic [IDX_W-1:0] IDX_VEC_LAST = IDX_W'(VEC_LEN - 1);

	typedef enum logic [2:0] {
		OP_LOAD  = 3'd0,
		OP_MUL   = 3'd1,
		OP_ADD   = 3'd2,
		OP_SCALE = 3'd3,
		OP_VEC   = 3'd4,
		OP_IDENT = 3'd5,
		OP_READ  = 3'd6
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_COPY
	} state_t;

	// sequencer to datapath control
	typedef struct packed {
		logic               accept;
		op_t                op;
		logic [IDX_W-1:0]   idx;
		logic [IDX_W-1:0]   elem;
		logic [TERM_W-1:0]  term;
		logic               mul_en;
		logic               acc_clr;
		logic               acc_en;
		logic               fin;
		logic               last;
		logic               copy;
	} seq_ctl_t;

	// identity matrix element at column-major index i
	function automatic elem_t ident_elem(input logic [IDX_W-1:0] i);
		return (i[1:0] == i[3:2]) ? ELEM_ONE : '0;
	endfunction

endpackage

// ===== rtl/m4t_mac.sv =====
module m4t_mac import m4t_pkg::*; (
	input  logic     clk,
	input  seq_ctl_t ctl,
	input  elem_t    a,
	input  elem_t    b,
	output elem_t    result
);

	logic signed [PROD_W-1:0] prod_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  prod_ext;
	logic signed [ACC_W-1:0]  sum;
	logic signed [ACC_W-1:0]  shifted;
	logic [ACC_W-ELEM_W:0]    hi;

	// shared multiplier, product registered
	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			prod_q <= a * b;
		end
	end

	assign prod_ext = {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};

	// accumulator
	always_ff @(posedge clk) begin
		if (ctl.acc_clr) begin
			acc_q <= '0;
		end else if (ctl.acc_en) begin
			acc_q <= acc_q + prod_ext;
		end
	end

	// final sum, floor shift, saturate
	assign sum     = acc_q + prod_ext;
	assign shifted = sum >>> FRAC_W;
	assign hi      = shifted[ACC_W-1:ELEM_W-1];

	always_comb begin
		if ((&hi) || !(|hi)) begin
			result = shifted[ELEM_W-1:0];
		end else begin
			result = shifted[ACC_W-1] ? ELEM_MIN : ELEM_MAX;
		end
	end

endmodule

// ===== rtl/m4t_store.sv =====
module m4t_store import m4t_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  seq_ctl_t         ctl,
	input  logic [2:0]       opcode,
	input  logic [IDX_W-1:0] elem_index,
	input  elem_t            operand_value,
	input  elem_t            result,
	output elem_t            a,
	output elem_t            b
);

	elem_t cur_q [NUM_ELEM];
	elem_t rhs_q [NUM_ELEM];
	elem_t res_q [NUM_ELEM];
	elem_t vec_q [VEC_LEN];
	elem_t val_q;

	op_t              in_op;
	logic [IDX_W-1:0] cur_addr;
	logic [IDX_W-1:0] rhs_addr;
	elem_t            cur_rd;

	assign in_op = op_t'(opcode);

	// current matrix, identity at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_ELEM; i++) begin
				cur_q[i] <= ident_elem(IDX_W'(i));
			end
		end else if (ctl.accept && in_op == OP_LOAD) begin
			cur_q[elem_index] <= operand_value;
		end else if (ctl.accept && in_op == OP_IDENT) begin
			for (int i = 0; i < NUM_ELEM; i++) begin
				cur_q[i] <= ident_elem(IDX_W'(i));
			end
		end else if (ctl.fin && ctl.op == OP_SCALE) begin
			cur_q[ctl.elem] <= result;
		end else if (ctl.fin && ctl.op == OP_ADD) begin
			cur_q[ctl.idx] <= result;
		end else if (ctl.copy) begin
			for (int i = 0; i < NUM_ELEM; i++) begin
				cur_q[i] <= res_q[i];
			end
		end
	end

	// operand buffers and product staging
	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			val_q <= operand_value;
		end
		if (ctl.accept && in_op == OP_MUL) begin
			rhs_q[elem_index] <= operand_value;
		end
		if (ctl.accept && in_op == OP_VEC && elem_index <= IDX_VEC_LAST) begin
			vec_q[elem_index[1:0]] <= operand_value;
		end
		if (ctl.fin && ctl.op == OP_MUL) begin
			res_q[ctl.elem] <= result;
		end
	end

	// read addresses
	always_comb begin
		rhs_addr = {ctl.elem[3:2], ctl.term};
		unique case (ctl.op)
			OP_MUL, OP_VEC: cur_addr = {ctl.term, ctl.elem[1:0]};
			OP_SCALE:       cur_addr = ctl.elem;
			default:        cur_addr = ctl.idx;
		endcase
	end

	assign cur_rd = cur_q[cur_addr];

	// operand select for the shared multiplier
	always_comb begin
		unique case (ctl.op)
			OP_MUL: begin
				a = cur_rd;
				b = rhs_q[rhs_addr];
			end
			OP_VEC: begin
				a = cur_rd;
				b = vec_q[ctl.term];
			end
			OP_SCALE: begin
				a = cur_rd;
				b = val_q;
			end
			OP_ADD: begin
				a = (ctl.term == '0) ? cur_rd : val_q;
				b = ELEM_ONE;
			end
			default: begin
				a = cur_rd;
				b = ELEM_ONE;
			end
		endcase
	end

endmodule

// ===== rtl/m4t_seq.sv =====
module m4t_seq import m4t_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [2:0]       opcode,
	input  logic [IDX_W-1:0] elem_index,
	output logic             busy,
	output seq_ctl_t         ctl
);

	state_t             state_q, state_d;
	op_t                op_q;
	logic [IDX_W-1:0]   idx_q;
	logic [IDX_W-1:0]   elem_q;
	logic [PHASE_W-1:0] phase_q;
	logic [PHASE_W-1:0] phase_last;
	logic [IDX_W-1:0]   elem_last;
	logic               accept;
	logic               go;
	logic               fin;
	logic               done_elem;
	op_t                in_op;

	assign in_op  = op_t'(opcode);
	assign accept = start && (state_q == ST_IDLE);

	// items that start a run of the shared unit
	always_comb begin
		unique case (in_op)
			OP_MUL:           go = (elem_index == IDX_MAT_LAST);
			OP_VEC:           go = (elem_index == IDX_VEC_LAST);
			OP_ADD, OP_SCALE,
			OP_READ:          go = 1'b1;
			default:          go = 1'b0;
		endcase
	end

	// terms per element and elements per run
	always_comb begin
		unique case (op_q)
			OP_MUL, OP_VEC: phase_last = PHASE_W'(VEC_LEN);
			OP_ADD:         phase_last = PHASE_W'(2);
			default:        phase_last = PHASE_W'(1);
		endcase
		unique case (op_q)
			OP_MUL, OP_SCALE: elem_last = IDX_MAT_LAST;
			OP_VEC:           elem_last = IDX_VEC_LAST;
			default:          elem_last = '0;
		endcase
	end

	assign fin       = (state_q == ST_RUN) && (phase_q == phase_last);
	assign done_elem = fin && (elem_q == elem_last);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && go) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (done_elem) begin
					state_d = (op_q == OP_MUL) ? ST_COPY : ST_IDLE;
				end
			end
			ST_COPY: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		busy        = (state_q != ST_IDLE);
		ctl.accept  = accept;
		ctl.op      = op_q;
		ctl.idx     = idx_q;
		ctl.elem    = elem_q;
		ctl.term    = phase_q[TERM_W-1:0];
		ctl.mul_en  = (state_q == ST_RUN) && (phase_q < phase_last);
		ctl.acc_clr = (state_q == ST_RUN) && (phase_q == '0);
		ctl.acc_en  = (state_q == ST_RUN) && (phase_q != '0) && (phase_q < phase_last);
		ctl.fin     = fin;
		ctl.last    = done_elem;
		ctl.copy    = (state_q == ST_COPY);
	end

	// state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_LOAD;
			idx_q   <= '0;
			elem_q  <= '0;
			phase_q <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				op_q    <= in_op;
				idx_q   <= elem_index;
				elem_q  <= '0;
				phase_q <= '0;
			end else if (state_q == ST_RUN) begin
				if (fin) begin
					phase_q <= '0;
					elem_q  <= elem_q + 1'b1;
				end else begin
					phase_q <= phase_q + 1'b1;
				end
			end
		end
	end

`ifndef SYNTH
	a_run_after_go: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && go) |=> (state_q == ST_RUN))
		else $error("run did not start after a triggering item");

	a_copy_after_mat: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COPY) |-> ($past(done_elem) && ($past(op_q) == OP_MUL)))
		else $error("copy without a finished matrix product");

	a_phase_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (phase_q <= phase_last))
		else $error("phase beyond term count");

	a_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(done_elem && (op_q != OP_MUL)) |=> (state_q == ST_IDLE))
		else $error("run did not end after its last element");
`endif

endmodule

// ===== rtl/matrix4_transform_unit.sv =====
// Busy per item: load, identity and buffered multiply/vector elements start no
// run and leave busy low; read, add, scale and product items hold it for a run.
// The shared 32x32 multiply-accumulate takes one term a cycle plus a finish step
// per element; results come one element per run of it, each registered and strobed
// in the cycle after its finish. The matrix product ends in a copy state.
// Reset (arst_n low, asynchronous) returns the matrix to identity and idles.
module matrix4_transform_unit import m4t_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [2:0]       opcode,
	input  logic [IDX_W-1:0] elem_index,
	input  elem_t            operand_value,
	output logic             strobe,
	output logic [IDX_W-1:0] out_index,
	output elem_t            out_value,
	output logic             last
);

	seq_ctl_t ctl;
	elem_t    op_a;
	elem_t    op_b;
	elem_t    result;
	logic     strobe_q;
	logic [IDX_W-1:0] out_index_q;
	elem_t    out_value_q;
	logic     last_q;

	m4t_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.opcode     (opcode),
		.elem_index (elem_index),
		.busy       (busy),
		.ctl        (ctl)
	);

	m4t_store u_store (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.opcode        (opcode),
		.elem_index    (elem_index),
		.operand_value (operand_value),
		.result        (result),
		.a             (op_a),
		.b             (op_b)
	);

	m4t_mac u_mac (
		.clk    (clk),
		.ctl    (ctl),
		.a      (op_a),
		.b      (op_b),
		.result (result)
	);

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= ctl.fin;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (ctl.fin) begin
			out_index_q <= (ctl.op == OP_ADD || ctl.op == OP_READ) ? ctl.idx : ctl.elem;
			out_value_q <= result;
			last_q      <= ctl.last;
		end
	end

	assign strobe    = strobe_q;
	assign out_index = out_index_q;
	assign out_value = out_value_q;
	assign last      = last_q;

endmodule

// ===== sim/tb_matrix4_transform_unit.sv =====
`timescale 1ns / 100ps

module tb_matrix4_transform_unit;
	import m4t_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int TAIL_CYCLES    = 100;
	localparam int PHASE_ITEMS    = 117;

	typedef elem_t col_t [VEC_LEN];

	// one command for the driver
	typedef struct {
		op_t              op;
		logic [IDX_W-1:0] idx;
		elem_t            val;
		int unsigned      idle_pct;
		bit               drain;
	} cmd_t;

	// one element coming back from the unit
	typedef struct {
		logic [IDX_W-1:0] idx;
		elem_t            value;
		logic             last;
	} elem_result_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	logic             busy;
	logic [2:0]       opcode = '0;
	logic [IDX_W-1:0] elem_index = '0;
	elem_t            operand_value = '0;
	logic             strobe;
	logic [IDX_W-1:0] out_index;
	elem_t            out_value;
	logic             last;

	cmd_t         cmd_queue [$];
	elem_result_t expected_elems [$];

	// shadow copy of the unit's state
	elem_t cur_mat [NUM_ELEM];
	elem_t rhs_buf [NUM_ELEM];
	col_t  vec_buf;

	// which buffer entries the stimulus has written so far
	logic [NUM_ELEM-1:0] rhs_written = '0;
	logic [VEC_LEN-1:0]  vec_written = '0;
	int unsigned         plan_count = 0;
	int unsigned         error_count = 0;
	int unsigned         idle_cycles = 0;

	matrix4_transform_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.opcode        (opcode),
		.elem_index    (elem_index),
		.operand_value (operand_value),
		.strobe        (strobe),
		.out_index     (out_index),
		.out_value     (out_value),
		.last          (last)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
	end

	task automatic report_mismatch(input string msg);
		if (error_count < 40)
			$display("ERROR %0t: %s", $time, msg);
		error_count++;
	endtask

	// ---------------- transform predictor ----------------

	function automatic elem_t saturate_elem(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] hi;
		logic signed [ACC_W-1:0] lo;
		hi = ELEM_MAX;
		lo = ELEM_MIN;
		if (v > hi)
			return ELEM_MAX;
		if (v < lo)
			return ELEM_MIN;
		return elem_t'(v);
	endfunction

	// row of the current matrix times a column, floor-shifted then clamped
	function automatic elem_t dot_row(input int row, input col_t col);
		logic signed [ACC_W-1:0]  acc;
		logic signed [PROD_W-1:0] prod;
		acc = '0;
		for (int k = 0; k < VEC_LEN; k++) begin
			prod = cur_mat[row + 4 * k] * col[k];
			acc = acc + prod;
		end
		return saturate_elem(acc >>> FRAC_W);
	endfunction

	task automatic load_identity();
		for (int i = 0; i < NUM_ELEM; i++)
			cur_mat[i] = (i % 4 == i / 4) ? ELEM_ONE : '0;
	endtask

	task automatic queue_result(input int idx, input elem_t value, input logic is_last);
		elem_result_t r;
		r.idx = IDX_W'(idx);
		r.value = value;
		r.last = is_last;
		expected_elems.push_back(r);
	endtask

	task automatic queue_matrix();
		for (int i = 0; i < NUM_ELEM; i++)
			queue_result(i, cur_mat[i], i == NUM_ELEM - 1);
	endtask

	task automatic apply_command(input op_t op, input logic [IDX_W-1:0] idx,
			input elem_t val);
		elem_t                    fresh [NUM_ELEM];
		col_t                     col;
		logic signed [ACC_W-1:0]  wide;
		logic signed [PROD_W-1:0] prod;
		case (op)
			OP_LOAD: cur_mat[idx] = val;
			OP_MUL: begin
				rhs_buf[idx] = val;
				if (idx == IDX_MAT_LAST) begin
					for (int i = 0; i < NUM_ELEM; i++) begin
						for (int k = 0; k < VEC_LEN; k++)
							col[k] = rhs_buf[(i / 4) * 4 + k];
						fresh[i] = dot_row(i % 4, col);
					end
					cur_mat = fresh;
					queue_matrix();
				end
			end
			OP_ADD: begin
				wide = cur_mat[idx];
				wide = wide + val;
				cur_mat[idx] = saturate_elem(wide);
				queue_result(idx, cur_mat[idx], 1'b1);
			end
			OP_SCALE: begin
				for (int i = 0; i < NUM_ELEM; i++) begin
					prod = cur_mat[i] * val;
					cur_mat[i] = saturate_elem(prod >>> FRAC_W);
				end
				queue_matrix();
			end
			OP_VEC: begin
				// components past the vector length are dropped
				if (idx < VEC_LEN) begin
					vec_buf[idx[1:0]] = val;
					if (idx == IDX_VEC_LAST)
						for (int r = 0; r < VEC_LEN; r++)
							queue_result(r, dot_row(r, vec_buf), r == VEC_LEN - 1);
				end
			end
			OP_IDENT: load_identity();
			OP_READ: queue_result(idx, cur_mat[idx], 1'b1);
			default: ;
		endcase
	endtask

	// ---------------- stimulus planning ----------------

	function automatic elem_t rand_elem();
		case ($urandom_range(9))
			0: return ELEM_MAX;
			1: return ELEM_MIN;
			2: return ELEM_ONE;
			3: return -ELEM_ONE;
			4, 5: return elem_t'($urandom);
			// tiny values exercise the floor rounding
			6: return elem_t'(int'($urandom_range(15)) - 8);
			default: return elem_t'(int'($urandom_range(1048575)) - 524288);
		endcase
	endfunction

	function automatic elem_t rand_scalar();
		if ($urandom_range(3) == 0)
			return rand_elem();
		return ELEM_ONE + elem_t'(int'($urandom_range(65535)) - 32768);
	endfunction

	task automatic plan(input op_t op, input int idx, input elem_t val,
			input int unsigned pct, input bit drain);
		cmd_t c;
		c.op = op;
		c.idx = IDX_W'(idx);
		c.val = val;
		c.idle_pct = pct;
		c.drain = drain;
		cmd_queue.push_back(c);
		if (op == OP_MUL)
			rhs_written[idx] = 1'b1;
		if (op == OP_VEC && idx < VEC_LEN)
			vec_written[idx] = 1'b1;
		if (!(op == OP_VEC && idx >= VEC_LEN))
			plan_count++;
	endtask

	initial begin
		int unsigned pct;
		int unsigned goal;
		int unsigned cut;
		int          order [15];
		int          tmp;
		int          j;

		load_identity();

		// directed: saturating adds, read, scale, identity, vector, product
		plan(OP_LOAD, 0, ELEM_MAX, 0, 0);
		plan(OP_ADD, 0, ELEM_ONE, 0, 0);
		plan(OP_LOAD, 5, ELEM_MIN, 0, 0);
		plan(OP_ADD, 5, -ELEM_ONE, 0, 0);
		plan(OP_READ, 15, '0, 0, 0);
		plan(OP_SCALE, 0, ELEM_MIN, 0, 0);
		plan(OP_IDENT, 0, '1, 0, 0);
		plan(OP_VEC, 9, ELEM_MAX, 0, 0);
		plan(OP_VEC, 0, ELEM_MAX, 0, 0);
		plan(OP_VEC, 1, ELEM_MIN, 0, 0);
		plan(OP_VEC, 2, -32'sd3, 0, 0);
		plan(OP_VEC, 3, ELEM_ONE, 0, 0);
		for (int i = 0; i < NUM_ELEM; i++)
			plan(OP_MUL, i, (i % 5 == 0) ? ELEM_MAX : elem_t'(-(i + 1) * 40000), 0, 0);

		// random: three idle regimes, mostly complete product sequences
		for (int ph = 0; ph < 3; ph++) begin
			pct = (ph == 0) ? 23 : (ph == 1) ? 51 : 0;
			goal = plan_count + PHASE_ITEMS;
			plan(OP_READ, $urandom_range(15), rand_elem(), pct, 1'b1);
			while (plan_count < goal) begin
				case ($urandom_range(19))
					0, 1, 2, 3, 4: begin
						for (int i = 0; i < 15; i++)
							order[i] = i;
						for (int i = 14; i > 0; i--) begin
							j = $urandom_range(i);
							tmp = order[i];
							order[i] = order[j];
							order[j] = tmp;
						end
						// now and then an unfinished sequence
						cut = ($urandom_range(4) == 0) ? $urandom_range(14) : 15;
						for (int i = 0; i < cut; i++) begin
							plan(OP_MUL, order[i], rand_elem(), pct, 1'b0);
							if ($urandom_range(19) == 0)
								plan(OP_READ, $urandom_range(15), rand_elem(), pct, 1'b0);
						end
						if (cut == 15)
							plan(OP_MUL, 15, rand_elem(), pct, $urandom_range(29) == 0);
					end
					5, 6, 7: begin
						for (int i = 0; i < 3; i++)
							order[i] = i;
						for (int i = 2; i > 0; i--) begin
							j = $urandom_range(i);
							tmp = order[i];
							order[i] = order[j];
							order[j] = tmp;
						end
						cut = ($urandom_range(4) == 0) ? $urandom_range(2) : 3;
						for (int i = 0; i < cut; i++) begin
							plan(OP_VEC, order[i], rand_elem(), pct, 1'b0);
							if ($urandom_range(7) == 0)
								plan(OP_VEC, $urandom_range(15, 4), rand_elem(), pct, 1'b0);
						end
						if (cut == 3)
							plan(OP_VEC, 3, rand_elem(), pct, $urandom_range(29) == 0);
					end
					8, 9, 10: plan(OP_LOAD, $urandom_range(15), rand_elem(), pct,
						$urandom_range(49) == 0);
					11, 12: plan(OP_ADD, $urandom_range(15), rand_elem(), pct,
						$urandom_range(49) == 0);
					13, 14: plan(OP_READ, $urandom_range(15), rand_elem(), pct,
						$urandom_range(49) == 0);
					15: plan(OP_SCALE, $urandom_range(15), rand_scalar(), pct, 1'b0);
					16: plan(OP_IDENT, $urandom_range(15), rand_elem(), pct, 1'b0);
					17: begin
						// re-trigger the product with the buffer as it stands
						if (&rhs_written[14:0])
							plan(OP_MUL, 15, rand_elem(), pct, 1'b0);
						else
							plan(OP_LOAD, $urandom_range(15), rand_elem(), pct, 1'b0);
					end
					default: begin
						if (&vec_written[2:0] && $urandom_range(1) == 0)
							plan(OP_VEC, 3, rand_elem(), pct, 1'b0);
						else
							plan(OP_VEC, $urandom_range(15, 4), rand_elem(), pct, 1'b0);
					end
				endcase
			end
		end

		// wait for the unit to drain, then watch for stray results
		@(posedge arst_n);
		while (cmd_queue.size() != 0 || start || expected_elems.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// ---------------- driver ----------------
	always @(posedge clk or negedge arst_n) begin
		logic next_start;
		cmd_t c;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			next_start = start;
			// item taken at this edge: predict from the values still on the ports
			if (start && !busy) begin
				apply_command(op_t'(opcode), elem_index, operand_value);
				next_start = 1'b0;
			end
			if (!next_start) begin
				if (cmd_queue.size() != 0
						&& !(cmd_queue[0].drain && expected_elems.size() != 0)
						&& $urandom_range(99) >= cmd_queue[0].idle_pct) begin
					c = cmd_queue.pop_front();
					opcode <= c.op;
					elem_index <= c.idx;
					operand_value <= c.val;
					next_start = 1'b1;
				end else begin
					// junk on the data lines while start is low
					opcode <= 3'($urandom);
					elem_index <= IDX_W'($urandom);
					operand_value <= elem_t'($urandom);
				end
			end
			start <= next_start;
		end
	end

	// ---------------- result monitor ----------------
	always @(posedge clk) begin
		elem_result_t want;
		if (arst_n && strobe) begin
			if (expected_elems.size() == 0) begin
				report_mismatch($sformatf("unexpected result idx=%0d value=%0h last=%b",
					out_index, out_value, last));
			end else begin
				want = expected_elems.pop_front();
				if (out_index !== want.idx)
					report_mismatch($sformatf("out_index %0d, expected %0d",
						out_index, want.idx));
				if (out_value !== want.value)
					report_mismatch($sformatf("out_value %0h at idx %0d, expected %0h",
						out_value, want.idx, want.value));
				if (last !== want.last)
					report_mismatch($sformatf("last %b at idx %0d, expected %b",
						last, want.idx, want.last));
			end
		end
	end

	// ---------------- watchdog ----------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((start && !busy) || strobe) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule

// ===== matrix4_transform_unit.f =====
rtl/m4t_pkg.sv
rtl/m4t_mac.sv
rtl/m4t_store.sv
rtl/m4t_seq.sv
rtl/matrix4_transform_unit.sv
sim/tb_matrix4_transform_unit.sv
